### hdl/mmc3mc_pkg.sv
// ----------------------------------------------------------------------------
// mmc3mc_pkg
// Shared types and constants of the multicart bank mapper: item and state
// records, opcode and register decode codes, and the fixed decode constants.
// ----------------------------------------------------------------------------
package mmc3mc_pkg;

    // Kind of one input word.
    typedef enum logic [1:0] {
        OP_CPU_WRITE  = 2'd0,
        OP_TICK       = 2'd1,
        OP_PRG_LOOKUP = 2'd2,
        OP_CHR_LOOKUP = 2'd3
    } t_opcode;

    // Inner register decode, built from {address[14:13], address[0]}.
    typedef enum logic [2:0] {
        REG_SELECT      = 3'b000,
        REG_BANK_DATA   = 3'b001,
        REG_MIRROR      = 3'b010,
        REG_OUTER       = 3'b011,
        REG_IRQ_COUNT   = 3'b100,
        REG_IRQ_RELOAD  = 3'b101,
        REG_IRQ_DISABLE = 3'b110,
        REG_IRQ_ENABLE  = 3'b111
    } t_reg_sel;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PATCHED_OUTER = 2'd0,
        CFG_CHR_ROM       = 2'd1,
        CFG_FOUR_SCREEN   = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    localparam logic [15:0] ADDR_OUTER_REG = 16'h6000;
    localparam logic [2:0]  OUTER_BIG      = 3'd6;
    localparam logic [2:0]  OUTER_CLAMP    = 3'd7;
    localparam logic [2:0]  SEL_PRG_A      = 3'd6;
    localparam logic [2:0]  SEL_PRG_B      = 3'd7;
    localparam int          CHR_REGS       = 6;

    localparam logic [CHR_REGS-1:0][7:0] CHR_BANKS_RESET =
        {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] address;
        logic [7:0]  data;
        logic [2:0]  slot;
        logic        rendering_active;
    } t_item;

    typedef struct packed {
        logic patched_outer_decode;
        logic chr_rom_present;
        logic four_screen;
    } t_cfg;

    typedef struct packed {
        logic [7:0]                 select_mode;
        logic [2:0]                 outer_bank;
        logic [7:0]                 prg_bank_a;
        logic [7:0]                 prg_bank_b;
        logic [CHR_REGS-1:0][7:0]   chr_banks;
        logic                       irq_enabled;
        logic [7:0]                 irq_count;
        logic [7:0]                 irq_reload;
        logic                       irq_pending;
        logic                       mirroring;
    } t_state;

    typedef struct packed {
        logic [9:0] bank_number;
        logic       bank_valid;
    } t_lookup;

endpackage

### hdl/mmc3mc_regs.sv
// ----------------------------------------------------------------------------
// mmc3mc_regs
// Mapper register file: configuration bits, CPU write decode, and the
// scanline interrupt counter. State advances by one item per step strobe.
// ----------------------------------------------------------------------------
module mmc3mc_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic                i_cfg_data,
    input  logic                i_step,
    input  mmc3mc_pkg::t_item   i_item,
    output mmc3mc_pkg::t_cfg    o_cfg,
    output mmc3mc_pkg::t_state  o_state,
    output mmc3mc_pkg::t_state  o_state_next
);

    mmc3mc_pkg::t_cfg    r_cfg;
    mmc3mc_pkg::t_state  r_state;
    mmc3mc_pkg::t_state  n_state;
    mmc3mc_pkg::t_reg_sel reg_sel;
    logic [7:0]          cnt_dec;
    logic [2:0]          bank_sel;

    assign reg_sel  = mmc3mc_pkg::t_reg_sel'({i_item.address[14:13], i_item.address[0]});
    assign cnt_dec  = r_state.irq_count - 8'd1;
    assign bank_sel = r_state.select_mode[2:0];

    always_comb begin
        n_state = r_state;
        unique case (i_item.opcode)
            mmc3mc_pkg::OP_CPU_WRITE: begin
                if (i_item.address == mmc3mc_pkg::ADDR_OUTER_REG) begin
                    if (r_cfg.patched_outer_decode) begin
                        n_state.outer_bank = {1'b0, i_item.data[2:1]};
                    end else begin
                        n_state.outer_bank = {1'b0, i_item.data[0], 1'b0};
                    end
                end else if (i_item.address[15]) begin
                    unique case (reg_sel)
                        mmc3mc_pkg::REG_SELECT: begin
                            n_state.select_mode = i_item.data;
                        end
                        mmc3mc_pkg::REG_BANK_DATA: begin
                            if (bank_sel == mmc3mc_pkg::SEL_PRG_A) begin
                                n_state.prg_bank_a = i_item.data;
                            end else if (bank_sel == mmc3mc_pkg::SEL_PRG_B) begin
                                n_state.prg_bank_b = i_item.data;
                            end else begin
                                for (int i = 0; i < mmc3mc_pkg::CHR_REGS; i++) begin
                                    if (bank_sel == 3'(i)) begin
                                        // The two 2KB banks ignore the low bit.
                                        n_state.chr_banks[i] = (i < 2) ?
                                            {i_item.data[7:1], 1'b0} : i_item.data;
                                    end
                                end
                            end
                        end
                        mmc3mc_pkg::REG_MIRROR: begin
                            if (!r_cfg.four_screen) begin
                                n_state.mirroring = i_item.data[0];
                            end
                        end
                        mmc3mc_pkg::REG_OUTER: begin
                            n_state.outer_bank =
                                (i_item.data[2:0] == mmc3mc_pkg::OUTER_CLAMP) ?
                                mmc3mc_pkg::OUTER_BIG : i_item.data[2:0];
                        end
                        mmc3mc_pkg::REG_IRQ_COUNT: begin
                            n_state.irq_count = i_item.data;
                        end
                        mmc3mc_pkg::REG_IRQ_RELOAD: begin
                            n_state.irq_reload = i_item.data;
                        end
                        mmc3mc_pkg::REG_IRQ_DISABLE: begin
                            n_state.irq_enabled = 1'b0;
                            n_state.irq_pending = 1'b0;
                        end
                        mmc3mc_pkg::REG_IRQ_ENABLE: begin
                            n_state.irq_enabled = 1'b1;
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            mmc3mc_pkg::OP_TICK: begin
                if (i_item.rendering_active && r_state.irq_enabled) begin
                    if (cnt_dec == 8'd0) begin
                        n_state.irq_count   = r_state.irq_reload;
                        n_state.irq_pending = 1'b1;
                    end else begin
                        n_state.irq_count = cnt_dec;
                    end
                end
            end
            default: begin
                // Lookups leave the state alone.
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.patched_outer_decode <= 1'b0;
            r_cfg.chr_rom_present      <= 1'b1;
            r_cfg.four_screen          <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (mmc3mc_pkg::t_cfg_index'(i_cfg_index))
                mmc3mc_pkg::CFG_PATCHED_OUTER: r_cfg.patched_outer_decode <= i_cfg_data;
                mmc3mc_pkg::CFG_CHR_ROM:       r_cfg.chr_rom_present      <= i_cfg_data;
                mmc3mc_pkg::CFG_FOUR_SCREEN:   r_cfg.four_screen          <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.select_mode <= 8'd0;
            r_state.outer_bank  <= 3'd0;
            r_state.prg_bank_a  <= 8'd0;
            r_state.prg_bank_b  <= 8'd1;
            r_state.chr_banks   <= mmc3mc_pkg::CHR_BANKS_RESET;
            r_state.irq_enabled <= 1'b0;
            r_state.irq_count   <= 8'd0;
            r_state.irq_reload  <= 8'd0;
            r_state.irq_pending <= 1'b0;
            r_state.mirroring   <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_cfg        = r_cfg;
    assign o_state      = r_state;
    assign o_state_next = n_state;

endmodule

### hdl/mmc3mc_lookup.sv
// ----------------------------------------------------------------------------
// mmc3mc_lookup
// Bank lookup: maps a PRG or CHR window to its bank number from the swap
// modes, the inner bank registers and the outer bank.
// ----------------------------------------------------------------------------
module mmc3mc_lookup (
    input  mmc3mc_pkg::t_item    i_item,
    input  mmc3mc_pkg::t_cfg     i_cfg,
    input  mmc3mc_pkg::t_state   i_state,
    output mmc3mc_pkg::t_lookup  o_lookup
);

    logic       big;
    logic [4:0] prg_mask;
    logic [4:0] prg_second_last;
    logic [4:0] prg_a;
    logic [4:0] prg_b;
    logic [4:0] prg_val;
    logic [1:0] prg_slot;
    logic [2:0] chr_slot;
    logic [2:0] chr_index;
    logic [7:0] chr_val;
    logic [7:0] chr_mask;
    logic [9:0] prg_bank;
    logic [9:0] chr_bank;

    assign big             = (i_state.outer_bank == mmc3mc_pkg::OUTER_BIG);
    assign prg_mask        = big ? 5'h1f : 5'h0f;
    assign prg_second_last = big ? 5'h1e : 5'h0e;
    assign prg_a           = prg_mask & i_state.prg_bank_a[4:0];
    assign prg_b           = prg_mask & i_state.prg_bank_b[4:0];
    assign prg_slot        = i_item.slot[1:0];

    always_comb begin
        // Bit 6 of the select register swaps the first and third windows.
        unique case (prg_slot)
            2'd0:    prg_val = i_state.select_mode[6] ? prg_second_last : prg_a;
            2'd1:    prg_val = prg_b;
            2'd2:    prg_val = i_state.select_mode[6] ? prg_a : prg_second_last;
            default: prg_val = prg_mask;
        endcase
    end

    assign prg_bank = {3'd0, i_state.outer_bank, 4'd0} | {5'd0, prg_val};

    // Bit 7 of the select register swaps the 2KB and 1KB halves.
    assign chr_slot  = i_item.slot ^ {i_state.select_mode[7], 2'b00};
    assign chr_index = chr_slot[2] ? ({1'b0, chr_slot[1:0]} + 3'd2) : {2'b00, chr_slot[1]};
    assign chr_val   = i_state.chr_banks[chr_index] + {7'd0, ~chr_slot[2] & chr_slot[0]};
    assign chr_mask  = big ? 8'hff : 8'h7f;
    assign chr_bank  = {i_state.outer_bank, 7'd0} | {2'd0, chr_val & chr_mask};

    always_comb begin
        o_lookup.bank_number = 10'd0;
        o_lookup.bank_valid  = 1'b0;
        if (i_item.opcode == mmc3mc_pkg::OP_PRG_LOOKUP) begin
            o_lookup.bank_number = prg_bank;
            o_lookup.bank_valid  = 1'b1;
        end else if (i_item.opcode == mmc3mc_pkg::OP_CHR_LOOKUP && i_cfg.chr_rom_present) begin
            o_lookup.bank_number = chr_bank;
            o_lookup.bank_valid  = 1'b1;
        end
    end

endmodule

### hdl/multicart_mmc3_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// multicart_mmc3_bank_mapper_unit
// Multicart bank mapper with scanline interrupt counter, streaming interface.
// ----------------------------------------------------------------------------
// A word accepted into the input register moves to the result register when
// that register is free or is being emptied. Throughput: one word per cycle
// while the result stream is ready, set by the single pass from the input
// register through the register file and lookup logic to the result register.
// Reset (synchronous, active low) empties both stages and returns the mapper
// registers and configuration bits to their power-on values.
// ----------------------------------------------------------------------------
module multicart_mmc3_bank_mapper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] address, [23:16] data, [26:24] slot, [27] rendering_active, [31:28] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [9:0] bank_number, [10] irq_line, [11] mirror_mode, [15:12] zero
    output logic [15:0] m_axis_tdata,
    // [0] bank_valid
    output logic        m_axis_tuser
);

    // The pipeline has two stages: an input register holding the accepted
    // word, and a result register. Every mapper register update happens as a
    // word moves from the first stage to the second, so updates stay in order.

    mmc3mc_pkg::t_item   r_in_item;
    logic                r_in_valid;
    mmc3mc_pkg::t_cfg    cfg;
    mmc3mc_pkg::t_state  state;
    mmc3mc_pkg::t_state  state_next;
    mmc3mc_pkg::t_lookup lookup;
    logic                advance;
    logic                in_take;

    logic                r_out_valid;
    logic [9:0]          r_out_bank;
    logic                r_out_bank_valid;
    logic                r_out_irq;
    logic                r_out_mirror;

    // The input stage moves on whenever the result register is free or is
    // being emptied in this cycle, so back-to-back words stall only on m_axis_tready.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // The user must write configuration only while the block is idle; the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.opcode           <= mmc3mc_pkg::t_opcode'(s_axis_tuser);
            r_in_item.address          <= s_axis_tdata[15:0];
            r_in_item.data             <= s_axis_tdata[23:16];
            r_in_item.slot             <= s_axis_tdata[26:24];
            r_in_item.rendering_active <= s_axis_tdata[27];
        end
    end

    mmc3mc_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_step       (advance),
        .i_item       (r_in_item),
        .o_cfg        (cfg),
        .o_state      (state),
        .o_state_next (state_next)
    );

    // Lookups never change the registers, so the current state serves them.
    mmc3mc_lookup u_lookup (
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .i_state  (state),
        .o_lookup (lookup)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The interrupt line and mirroring reported are the values after the word.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_bank       <= lookup.bank_number;
            r_out_bank_valid <= lookup.bank_valid;
            r_out_irq        <= state_next.irq_pending;
            r_out_mirror     <= state_next.mirroring;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_mirror, r_out_irq, r_out_bank};
    assign m_axis_tuser  = r_out_bank_valid;

endmodule
